[rtl/core/dbcq_pkg.sv]
`timescale 1ns / 1ps
package dbcq_pkg;
  localparam int RingDepthDefault = 8;
  localparam logic [31:0] AllOnes  = 32'hFFFF_FFFF;
  localparam logic [31:0] AsyncCap = 32'h8000_0000;

  localparam logic [1:0] ReqRead = 2'd0;
  localparam logic [1:0] ReqWrite = 2'd1;
  localparam logic [1:0] ReqDone = 2'd2;

  localparam logic [1:0] KindRead = 2'd0;
  localparam logic [1:0] KindAck = 2'd1;
  localparam logic [1:0] KindDispatch = 2'd2;
  localparam logic [1:0] KindExecReset = 2'd3;

  localparam logic [1:0] WaitNone = 2'd0;
  localparam logic [1:0] WaitSpace = 2'd1;
  localparam logic [1:0] WaitFence = 2'd2;
  localparam logic [1:0] WaitReset = 2'd3;

  localparam logic [4:0] RegMagic = 5'd0;
  localparam logic [4:0] RegVersion = 5'd1;
  localparam logic [4:0] RegCaps = 5'd2;
  localparam logic [4:0] RegShmem = 5'd3;
  localparam logic [4:0] RegBackend = 5'd4;
  localparam logic [4:0] RegDepth = 5'd5;
  localparam logic [4:0] RegOffset = 5'd6;
  localparam logic [4:0] RegLength = 5'd7;
  localparam logic [4:0] RegDoorbell = 5'd8;
  localparam logic [4:0] RegFree = 5'd9;
  localparam logic [4:0] RegFence = 5'd10;
  localparam logic [4:0] RegSubmitted = 5'd11;
  localparam logic [4:0] RegSubmitSt = 5'd12;
  localparam logic [4:0] RegStatus = 5'd13;
  localparam logic [4:0] RegPc = 5'd14;
  localparam logic [4:0] RegErrors = 5'd15;
  localparam logic [4:0] RegIrq = 5'd16;
  localparam logic [4:0] RegIrqMask = 5'd17;
  localparam logic [4:0] RegDebug = 5'd18;

  localparam logic [2:0] CfgMagic = 3'd0;
  localparam logic [2:0] CfgVersion = 3'd1;
  localparam logic [2:0] CfgCaps = 3'd2;
  localparam logic [2:0] CfgShmem = 3'd3;
  localparam logic [2:0] CfgBackend = 3'd4;

  // Ring write request from the control unit to the job ring.
  typedef struct packed {
    logic        we;
    logic [31:0] offset;
    logic [31:0] length;
  } ring_wr_t;
endpackage

[rtl/core/dbcq_ring.sv]
`timescale 1ns / 1ps
module dbcq_ring #(
  parameter int RING_DEPTH = dbcq_pkg::RingDepthDefault,
  localparam int AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1
) (
  input  logic                 clk,
  input  dbcq_pkg::ring_wr_t   wr,
  input  logic [AW-1:0]        wr_addr,
  input  logic [AW-1:0]        rd_addr,
  output logic [31:0]          rd_offset,
  output logic [31:0]          rd_length
);
  logic [63:0] mem [RING_DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr_addr] <= {wr.offset, wr.length};
    end
    {rd_offset, rd_length} <= mem[rd_addr];
  end
endmodule

[rtl/core/doorbell_command_queue_with_fences.sv]
`timescale 1ns / 1ps
// Doorbell command queue with fences.
// Channels: one command input (start/busy) carrying a bus read, a bus write
// or an executor completion; one result output that presents each result
// for exactly one cycle under result_valid, with last on the final one of
// an item. Identity words are loaded through the cfg_we/cfg_index/cfg_data
// write port; the user must load them only while the block is idle, as the
// block itself does not enforce it. Order: a read answers in the cycle after
// acceptance; a plain write answers from the StAck state. An item that
// queues a job while no job is running writes the ring, then reads the head
// entry from the ring memory through its registered read port in StRead and
// issues the dispatch in StDisp; busy is high whenever the state is not StIdle.
// Held writes (synchronous submit, soft reset with a running job) give no
// result until a later completion releases them; bus requests in between
// are dropped with no result.
// Reset: rst clears all control state and identity words. The ring entries
// are not cleared; an entry is always written before it is dispatched.
// The receiver cannot stall: every result is taken the cycle it is shown.
module doorbell_command_queue_with_fences #(
  parameter int RING_DEPTH = dbcq_pkg::RingDepthDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  req_type,
  input  logic [4:0]  reg_index,
  input  logic [31:0] write_data,
  input  logic [7:0]  done_status,
  input  logic [31:0] done_pc,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output logic        result_valid,
  output logic [1:0]  result_kind,
  output logic [31:0] read_data,
  output logic [31:0] job_offset,
  output logic [31:0] job_length,
  output logic        irq_level,
  output logic        last
);
  localparam int AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int CW = $clog2(RING_DEPTH + 1);
  localparam logic [CW-1:0] DepthC = CW'(RING_DEPTH);

  typedef enum logic [4:0] {
    StIdle = 5'b00001,
    StRead = 5'b00010,
    StDisp = 5'b00100,
    StAck  = 5'b01000,
    StAck2 = 5'b10000
  } state_t;

  state_t state;
  logic [31:0] device_magic, proto_version, caps_word, shmem_bytes, backend_tag;
  logic [AW-1:0] ring_head;
  logic [CW-1:0] ring_count;
  logic job_running, irq_pending, irq_enable, submit_result;
  logic [31:0] submitted_count, fence_count, last_pc, error_count;
  logic [31:0] staged_offset, staged_length, wait_target;
  logic [7:0] last_status;
  logic [1:0] wait_mode;
  logic ack_after, ack_last;

  dbcq_pkg::ring_wr_t ring_wr;
  logic [AW-1:0] wr_addr;
  logic [31:0] rd_offset, rd_length;

  function automatic logic [AW-1:0] wrap(input logic [AW:0] v);
    logic [AW:0] r;
    r = (v >= (AW+1)'(RING_DEPTH)) ? v - (AW+1)'(RING_DEPTH) : v;
    return r[AW-1:0];
  endfunction

  assign wr_addr = wrap({1'b0, ring_head} + (AW+1)'(ring_count));

  dbcq_ring #(.RING_DEPTH(RING_DEPTH)) u_ring (
    .clk(clk), .wr(ring_wr), .wr_addr(wr_addr), .rd_addr(ring_head),
    .rd_offset(rd_offset), .rd_length(rd_length)
  );

  assign busy = (state != StIdle);

  // Register read mux.
  logic [31:0] rd_val;
  always_comb begin
    case (reg_index)
      dbcq_pkg::RegMagic:     rd_val = device_magic;
      dbcq_pkg::RegVersion:   rd_val = proto_version;
      dbcq_pkg::RegCaps:      rd_val = caps_word | dbcq_pkg::AsyncCap;
      dbcq_pkg::RegShmem:     rd_val = shmem_bytes;
      dbcq_pkg::RegBackend:   rd_val = backend_tag;
      dbcq_pkg::RegDepth:     rd_val = 32'(RING_DEPTH);
      dbcq_pkg::RegOffset:    rd_val = staged_offset;
      dbcq_pkg::RegLength:    rd_val = staged_length;
      dbcq_pkg::RegDoorbell:  rd_val = 32'(ring_count);
      dbcq_pkg::RegFree:      rd_val = 32'(DepthC - ring_count);
      dbcq_pkg::RegFence:     rd_val = fence_count;
      dbcq_pkg::RegSubmitted: rd_val = submitted_count;
      dbcq_pkg::RegSubmitSt:  rd_val = {31'd0, submit_result};
      dbcq_pkg::RegStatus:    rd_val = {24'd0, last_status};
      dbcq_pkg::RegPc:        rd_val = last_pc;
      dbcq_pkg::RegErrors:    rd_val = error_count;
      dbcq_pkg::RegIrq:       rd_val = {31'd0, irq_pending};
      dbcq_pkg::RegIrqMask:   rd_val = {31'd0, irq_enable};
      dbcq_pkg::RegDebug:     rd_val = 32'd0;
      default:                rd_val = dbcq_pkg::AllOnes;
    endcase
  end

  logic accept;
  assign accept = start && !busy;

  logic can_disp;
  assign can_disp = !job_running && (ring_count != '0);

  // Ring write only when queueing the staged job.
  always_comb begin
    ring_wr.offset = staged_offset;
    ring_wr.length = staged_length;
    ring_wr.we = 1'b0;
    if (accept && wait_mode == dbcq_pkg::WaitNone && req_type == dbcq_pkg::ReqWrite &&
        reg_index == dbcq_pkg::RegDoorbell && write_data[0] && ring_count < DepthC) begin
      ring_wr.we = 1'b1;
    end
    if (accept && req_type == dbcq_pkg::ReqDone && job_running &&
        wait_mode == dbcq_pkg::WaitSpace) begin
      ring_wr.we = 1'b1;  // the completion frees one slot, which this write fills
    end
  end

  // Main control: the state update happens at acceptance; the follow-up
  // states issue the dispatch and deferred acknowledges.
  always_ff @(posedge clk) begin
    result_valid <= 1'b0;
    if (rst) begin
      state <= StIdle;
      {device_magic, proto_version, caps_word, shmem_bytes, backend_tag} <= '0;
      ring_head <= '0; ring_count <= '0; job_running <= 1'b0;
      submitted_count <= '0; fence_count <= '0; last_status <= '0;
      last_pc <= '0; error_count <= '0; irq_pending <= 1'b0;
      irq_enable <= 1'b0; staged_offset <= '0; staged_length <= '0;
      submit_result <= 1'b0; wait_mode <= dbcq_pkg::WaitNone;
      wait_target <= '0; ack_after <= 1'b0; ack_last <= 1'b0;
      result_valid <= 1'b0;
      result_kind <= '0; read_data <= '0; job_offset <= '0; job_length <= '0;
      irq_level <= 1'b0; last <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          dbcq_pkg::CfgMagic:   device_magic <= cfg_data;
          dbcq_pkg::CfgVersion: proto_version <= cfg_data;
          dbcq_pkg::CfgCaps:    caps_word <= cfg_data;
          dbcq_pkg::CfgShmem:   shmem_bytes <= cfg_data;
          dbcq_pkg::CfgBackend: backend_tag <= cfg_data;
          default: ;
        endcase
      end
      read_data <= '0; job_offset <= '0; job_length <= '0;
      case (state)
        StIdle: begin
          if (accept) begin
            if (req_type == dbcq_pkg::ReqRead && wait_mode == dbcq_pkg::WaitNone) begin
              result_valid <= 1'b1; result_kind <= dbcq_pkg::KindRead;
              read_data <= rd_val; irq_level <= irq_pending & irq_enable;
              last <= 1'b1;
            end else if (req_type == dbcq_pkg::ReqWrite &&
                         wait_mode == dbcq_pkg::WaitNone) begin
              ack_after <= 1'b1; ack_last <= 1'b0;
              state <= StAck;
              case (reg_index)
                dbcq_pkg::RegMagic: begin
                  if (job_running) begin
                    ring_count <= CW'(1);
                    wait_mode <= dbcq_pkg::WaitReset;
                    ack_after <= 1'b0;
                    state <= StIdle;
                  end else begin
                    ring_head <= '0; ring_count <= '0; submitted_count <= '0;
                    fence_count <= '0; last_status <= '0; last_pc <= '0;
                    error_count <= '0; irq_pending <= 1'b0; irq_enable <= 1'b0;
                    staged_offset <= '0; staged_length <= '0;
                    submit_result <= 1'b0; wait_target <= '0;
                    result_valid <= 1'b1; result_kind <= dbcq_pkg::KindExecReset;
                    irq_level <= 1'b0; last <= 1'b0;
                  end
                end
                dbcq_pkg::RegOffset: staged_offset <= write_data;
                dbcq_pkg::RegLength: staged_length <= write_data;
                dbcq_pkg::RegDoorbell: begin
                  if (write_data[0]) begin
                    if (ring_count >= DepthC) begin
                      if (write_data[1]) begin
                        submit_result <= 1'b1;
                      end else begin
                        wait_mode <= dbcq_pkg::WaitSpace;
                        ack_after <= 1'b0;
                        state <= StIdle;
                      end
                    end else begin
                      ring_count <= ring_count + CW'(1);
                      submitted_count <= submitted_count + 32'd1;
                      if (!job_running) state <= StRead;
                      if (!write_data[1]) begin
                        wait_target <= submitted_count + 32'd1;
                        wait_mode <= dbcq_pkg::WaitFence;
                        ack_after <= 1'b0;
                        if (job_running) state <= StIdle;
                      end else begin
                        submit_result <= 1'b0;
                      end
                    end
                  end
                end
                dbcq_pkg::RegIrq: if (write_data[0]) irq_pending <= 1'b0;
                dbcq_pkg::RegIrqMask: irq_enable <= write_data[0];
                default: ;
              endcase
            end else if (req_type == dbcq_pkg::ReqDone && job_running) begin
              last_status <= done_status;
              last_pc <= done_pc;
              if (done_status != 8'd0) error_count <= error_count + 32'd1;
              fence_count <= fence_count + 32'd1;
              irq_pending <= 1'b1;
              ring_head <= wrap({1'b0, ring_head} + (AW+1)'(1));
              job_running <= 1'b0;
              ack_after <= 1'b0;
              if (wait_mode == dbcq_pkg::WaitReset) begin
                ring_head <= '0; ring_count <= '0; submitted_count <= '0;
                fence_count <= '0; last_status <= '0; last_pc <= '0;
                error_count <= '0; irq_pending <= 1'b0; irq_enable <= 1'b0;
                staged_offset <= '0; staged_length <= '0;
                submit_result <= 1'b0; wait_target <= '0;
                wait_mode <= dbcq_pkg::WaitNone;
                result_valid <= 1'b1; result_kind <= dbcq_pkg::KindExecReset;
                irq_level <= 1'b0; last <= 1'b0;
                ack_last <= 1'b1;
                state <= StAck;
              end else begin
                logic [CW-1:0] cnt;
                logic [31:0] fc, tgt, diff;
                logic [1:0] wm;
                logic rel;
                cnt = (ring_count != '0) ? ring_count - CW'(1) : ring_count;
                fc = fence_count + 32'd1;
                tgt = wait_target;
                wm = wait_mode;
                if (wm == dbcq_pkg::WaitSpace) begin
                  cnt = cnt + CW'(1);
                  submitted_count <= submitted_count + 32'd1;
                  tgt = submitted_count + 32'd1;
                  wm = dbcq_pkg::WaitFence;
                end
                // The fence is reached once the signed distance is not negative.
                diff = fc - tgt;
                rel = (wm == dbcq_pkg::WaitFence) && !diff[31];
                if (rel) begin
                  submit_result <= 1'b0;
                  wm = dbcq_pkg::WaitNone;
                  result_valid <= 1'b1; result_kind <= dbcq_pkg::KindAck;
                  irq_level <= irq_enable; last <= (cnt == '0);
                end
                ring_count <= cnt;
                wait_target <= tgt;
                wait_mode <= wm;
                if (cnt != '0) state <= StRead;
              end
            end
          end
        end
        StRead: state <= StDisp;
        StDisp: begin
          if (can_disp && wait_mode != dbcq_pkg::WaitReset) begin
            job_running <= 1'b1;
            result_valid <= 1'b1; result_kind <= dbcq_pkg::KindDispatch;
            job_offset <= rd_offset; job_length <= rd_length;
            irq_level <= irq_pending & irq_enable;
            last <= !ack_after;
          end
          state <= ack_after ? StAck : StIdle;
        end
        StAck: begin
          result_valid <= 1'b1; result_kind <= dbcq_pkg::KindAck;
          irq_level <= irq_pending & irq_enable; last <= 1'b1;
          ack_after <= 1'b0;
          state <= ack_last ? StAck2 : StIdle;
          ack_last <= 1'b0;
        end
        StAck2: state <= StIdle;
        default: state <= StIdle;
      endcase
    end
  end

  // Checks on the control logic.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    ring_count <= DepthC) else $error("ring count above depth");
  a_dispatch_sets_running: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_kind == dbcq_pkg::KindDispatch |-> job_running)
    else $error("dispatch without running job");
  a_idle_no_hold: assert property (@(posedge clk) disable iff (rst)
    state == StIdle |-> !ack_after || $past(state) != StIdle)
    else $error("pending acknowledge lost");
endmodule
